/* src/imu_ups_pkg.sv */
// imu_ups_pkg: shared types, constants and the cordic arctangent table
// for the imu sample upsampler; no dependencies
`default_nettype none

package imu_ups_pkg;

  localparam int MAX_FILL_DEF   = 63;
  localparam int ALPHA_BITS_DEF = 24;

  localparam logic [29:0] PERIOD_RESET = 30'd2000000;
  localparam logic [2:0]  REG_PERIOD   = 3'd0;   // register index of sample_period_ns

  localparam logic signed [35:0] Q30_ONE    = 36'sd1073741824;
  localparam logic signed [35:0] LINEAR_EPS = 36'sd1024;
  localparam logic signed [35:0] GAIN_INV   = 36'sh026DD3B6A;
  localparam logic [4:0]         CORDIC_LAST = 5'd30;

  typedef enum logic [4:0] {
    S_IDLE, S_GAP, S_DOT, S_SQ, S_SQRT, S_ANG, S_KSTART, S_ALPHA, S_SCALE,
    S_A1, S_SIN0, S_DIV0, S_SIN1, S_DIV1, S_QMUL, S_LMUL, S_EMIT, S_RAW
  } state_t;

  // atan(2^-i) in q30 radians
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* src/imu_sample_upsampler_slerp_top.sv */
// imu upsampler: one sample in, up to MAX_FILL interpolated samples and the raw one out.
// No fills: the raw result is registered after accept. Otherwise setup (near-parallel or slerp),
// then per fill the steps of the shared multiplier, the bit-serial dividers and the 31-step
// cordic, then the raw sample, plus output waits. sample_stall is high in work.
// Synchronous reset clears the control, the previous-sample valid flag and timestamp and the
// period register.
`default_nettype none

module imu_sample_upsampler_slerp_top #(
  parameter int MAX_FILL   = imu_ups_pkg::MAX_FILL_DEF,
  parameter int ALPHA_BITS = imu_ups_pkg::ALPHA_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst,
  // apb configuration
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire         [2:0]  paddr,
  input  wire         [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready,
  // sample request
  input  wire                sample_valid,
  output logic               sample_stall,
  input  wire         [62:0] timestamp_ns,
  input  wire signed  [31:0] quat_w,
  input  wire signed  [31:0] quat_x,
  input  wire signed  [31:0] quat_y,
  input  wire signed  [31:0] quat_z,
  input  wire signed  [31:0] gyro_x,
  input  wire signed  [31:0] gyro_y,
  input  wire signed  [31:0] gyro_z,
  input  wire signed  [31:0] accel_x,
  input  wire signed  [31:0] accel_y,
  input  wire signed  [31:0] accel_z,
  // result request
  output logic               result_valid,
  input  wire                result_stall,
  output logic        [62:0] out_timestamp_ns,
  output logic signed [31:0] out_quat_w,
  output logic signed [31:0] out_quat_x,
  output logic signed [31:0] out_quat_y,
  output logic signed [31:0] out_quat_z,
  output logic signed [31:0] out_gyro_x,
  output logic signed [31:0] out_gyro_y,
  output logic signed [31:0] out_gyro_z,
  output logic signed [31:0] out_accel_x,
  output logic signed [31:0] out_accel_y,
  output logic signed [31:0] out_accel_z,
  output logic               last_of_run
);

  localparam int AB = ALPHA_BITS;
  localparam int UP = (AB >= 30) ? 0 : 30 - AB;
  localparam int DN = (AB >= 30) ? AB - 30 : 0;

  imu_ups_pkg::state_t state, state_next;

  logic [29:0] period;
  logic        prev_valid;
  logic [62:0] prev_time;
  logic signed [31:0] prev_q [4];
  logic signed [31:0] prev_g [3];
  logic signed [31:0] prev_a [3];
  logic [62:0] cur_time;
  logic signed [31:0] cur_q [4];
  logic signed [31:0] cur_g [3];
  logic signed [31:0] cur_a [3];
  logic [62:0] gap;
  logic [5:0]  cnt;
  logic [5:0]  kidx;
  logic [36:0] kp;
  logic signed [35:0] dot;
  logic        lin;
  logic [63:0] sq_n, sq_res, sq_bit;
  logic [30:0] sinth;
  logic signed [35:0] cx, cy, cz, theta, a1;
  logic [63:0] arem;
  logic [AB-1:0] alpha;
  logic [32:0] drem;
  logic [29:0] dq;
  logic signed [31:0] s0, s1;
  logic signed [65:0] acc;
  logic signed [31:0] res_q [4];
  logic signed [31:0] res_l [6];
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mprod;

  // apb register port
  assign pready = 1'b1;
  assign prdata = (paddr == imu_ups_pkg::REG_PERIOD) ? {2'b00, period} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= imu_ups_pkg::PERIOD_RESET;
    end else if (psel && penable && pwrite && (paddr == imu_ups_pkg::REG_PERIOD)) begin
      period <= pwdata[29:0];
    end
  end

  // derived values
  logic signed [35:0] dot_abs;
  logic               negd, lin_d;
  logic [29:0]        t30;
  logic [62:0]        gap_d;
  logic               go, next_ok, out_free, out_load;
  assign negd    = dot[35];
  assign dot_abs = negd ? -dot : dot;
  assign lin_d   = dot_abs >= (imu_ups_pkg::Q30_ONE - imu_ups_pkg::LINEAR_EPS);
  assign t30     = 30'((64'(alpha) << UP) >> DN);
  assign gap_d   = cur_time - prev_time;
  assign go      = prev_valid && (cur_time > prev_time) && (period != 30'd0) &&
                   ({32'd0, period, 1'b0} <= gap_d);
  assign next_ok = (kidx < 6'(MAX_FILL)) &&
                   (63'({1'b0, kp} + {7'd0, period, 1'b0}) <= gap);
  assign out_free = !result_valid || !result_stall;

  // cordic step, vectoring in S_ANG, rotation elsewhere
  logic signed [35:0] sh_x, sh_y, at_v, cx_n, cy_n, cz_n, sn_c;
  logic               cdir, sn_ge;
  assign sh_x = cx >>> cnt[4:0];
  assign sh_y = cy >>> cnt[4:0];
  assign at_v = 36'(imu_ups_pkg::atan_q30(cnt[4:0]));
  assign cdir = (state == imu_ups_pkg::S_ANG) ? (cy > 36'sd0) : (cz < 36'sd0);
  assign cx_n = cdir ? cx + sh_y : cx - sh_y;
  assign cy_n = cdir ? cy - sh_x : cy + sh_x;
  assign cz_n = cdir ? cz + at_v : cz - at_v;
  assign sn_c  = (cy_n < 36'sd0) ? 36'sd0 : cy_n;
  assign sn_ge = sn_c >= $signed({5'd0, sinth});

  // integer square root step
  logic [63:0] sq_t;
  logic        sq_ge;
  assign sq_t  = sq_res + sq_bit;
  assign sq_ge = sq_n >= sq_t;

  // alpha division step
  logic [63:0] ar2;
  logic        a_ge;
  assign ar2  = {arem[62:0], 1'b0};
  assign a_ge = ar2 >= {1'b0, gap};

  // scale division step
  logic [32:0] dr2;
  logic        d_ge;
  logic [29:0] dq_n;
  assign dr2  = {drem[31:0], 1'b0};
  assign d_ge = dr2 >= {2'b00, sinth};
  assign dq_n = {dq[28:0], d_ge};

  // lerp operands, gyro then accel
  logic signed [31:0] lp_a [6];
  logic signed [31:0] lp_b [6];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lp_a[i]     = prev_g[i];
      lp_b[i]     = cur_g[i];
      lp_a[i + 3] = prev_a[i];
      lp_b[i + 3] = cur_a[i];
    end
  end

  logic [2:0]         li, lc;
  logic signed [32:0] ldiff, cdiff;
  logic [32:0]        lmag;
  assign li    = cnt[2:0];
  assign lc    = cnt[2:0] - 3'd1;
  assign ldiff = 33'(lp_b[li]) - 33'(lp_a[li]);
  assign lmag  = ldiff[32] ? 33'(-ldiff) : 33'(ldiff);
  assign cdiff = 33'(lp_b[lc]) - 33'(lp_a[lc]);

  logic [65:0] lsum;
  logic [32:0] lstep;
  assign lsum  = 66'(mprod) + (66'd1 << (AB - 1));
  assign lstep = 33'(lsum >> AB);

  // quaternion component finish
  logic [1:0]         qi;
  logic signed [65:0] qv;
  logic signed [35:0] qs;
  logic signed [31:0] qsat;
  assign qi = 2'((cnt - 6'd1) >> 1);
  assign qv = acc + 66'(mprod) + 66'sd536870912;
  assign qs = 36'(qv >>> 30);
  always_comb begin
    if (qs > 36'sd2147483647)       qsat = 32'sh7FFFFFFF;
    else if (qs < -36'sd2147483648) qsat = 32'sh80000000;
    else                            qsat = 32'(qs);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = 34'sd0;
    mul_b = 34'sd0;
    unique case (state)
      imu_ups_pkg::S_DOT: begin
        mul_a = 34'(prev_q[cnt[1:0]]);
        mul_b = 34'(cur_q[cnt[1:0]]);
      end
      imu_ups_pkg::S_SQ: begin
        mul_a = 34'(dot_abs);
        mul_b = 34'(dot_abs);
      end
      imu_ups_pkg::S_A1: begin
        mul_a = $signed({4'd0, t30});
        mul_b = 34'(theta);
      end
      imu_ups_pkg::S_QMUL: begin
        if (cnt[0]) begin
          mul_a = 34'(s1);
          mul_b = 34'(cur_q[cnt[2:1]]);
        end else begin
          mul_a = 34'(s0);
          mul_b = 34'(prev_q[cnt[2:1]]);
        end
      end
      imu_ups_pkg::S_LMUL: begin
        mul_a = $signed({1'b0, lmag});
        mul_b = $signed(34'(alpha));
      end
      default: begin
        mul_a = 34'sd0;
        mul_b = 34'sd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mprod <= mul_a * mul_b;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      imu_ups_pkg::S_IDLE:   if (sample_valid) state_next = imu_ups_pkg::S_GAP;
      imu_ups_pkg::S_GAP:    state_next = go ? imu_ups_pkg::S_DOT : imu_ups_pkg::S_RAW;
      imu_ups_pkg::S_DOT:
        if (cnt == 6'd5) state_next = lin_d ? imu_ups_pkg::S_KSTART : imu_ups_pkg::S_SQ;
      imu_ups_pkg::S_SQ:     if (cnt == 6'd1) state_next = imu_ups_pkg::S_SQRT;
      imu_ups_pkg::S_SQRT:
        if (sq_bit == 64'd0)
          state_next = (sq_res == 64'd0) ? imu_ups_pkg::S_KSTART : imu_ups_pkg::S_ANG;
      imu_ups_pkg::S_ANG:
        if (cnt[4:0] == imu_ups_pkg::CORDIC_LAST) state_next = imu_ups_pkg::S_KSTART;
      imu_ups_pkg::S_KSTART: state_next = imu_ups_pkg::S_ALPHA;
      imu_ups_pkg::S_ALPHA:  if (cnt == 6'(AB - 1)) state_next = imu_ups_pkg::S_SCALE;
      imu_ups_pkg::S_SCALE:  state_next = lin ? imu_ups_pkg::S_QMUL : imu_ups_pkg::S_A1;
      imu_ups_pkg::S_A1:     if (cnt == 6'd1) state_next = imu_ups_pkg::S_SIN0;
      imu_ups_pkg::S_SIN0:
        if (cnt[4:0] == imu_ups_pkg::CORDIC_LAST)
          state_next = sn_ge ? imu_ups_pkg::S_SIN1 : imu_ups_pkg::S_DIV0;
      imu_ups_pkg::S_DIV0:   if (cnt == 6'd29) state_next = imu_ups_pkg::S_SIN1;
      imu_ups_pkg::S_SIN1:
        if (cnt[4:0] == imu_ups_pkg::CORDIC_LAST)
          state_next = sn_ge ? imu_ups_pkg::S_QMUL : imu_ups_pkg::S_DIV1;
      imu_ups_pkg::S_DIV1:   if (cnt == 6'd29) state_next = imu_ups_pkg::S_QMUL;
      imu_ups_pkg::S_QMUL:   if (cnt == 6'd8) state_next = imu_ups_pkg::S_LMUL;
      imu_ups_pkg::S_LMUL:   if (cnt == 6'd6) state_next = imu_ups_pkg::S_EMIT;
      imu_ups_pkg::S_EMIT:
        if (out_free) state_next = next_ok ? imu_ups_pkg::S_KSTART : imu_ups_pkg::S_RAW;
      imu_ups_pkg::S_RAW:    if (out_free) state_next = imu_ups_pkg::S_IDLE;
      default:               state_next = imu_ups_pkg::S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    sample_stall = (state != imu_ups_pkg::S_IDLE);
    out_load     = out_free && ((state == imu_ups_pkg::S_EMIT) ||
                                (state == imu_ups_pkg::S_RAW));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= imu_ups_pkg::S_IDLE;
      cnt          <= 6'd0;
      prev_valid   <= 1'b0;
      prev_time    <= 63'd0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? 6'd0 : cnt + 6'd1;
      if (out_load) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
      if (state == imu_ups_pkg::S_RAW && out_free) begin
        prev_valid <= 1'b1;
        prev_time  <= cur_time;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      imu_ups_pkg::S_IDLE: begin
        if (sample_valid) begin
          cur_time <= timestamp_ns;
          cur_q[0] <= quat_w;
          cur_q[1] <= quat_x;
          cur_q[2] <= quat_y;
          cur_q[3] <= quat_z;
          cur_g[0] <= gyro_x;
          cur_g[1] <= gyro_y;
          cur_g[2] <= gyro_z;
          cur_a[0] <= accel_x;
          cur_a[1] <= accel_y;
          cur_a[2] <= accel_z;
        end
      end
      imu_ups_pkg::S_GAP: begin
        gap  <= gap_d;
        kidx <= 6'd1;
        kp   <= {7'd0, period};
        dot  <= 36'sd0;
        lin  <= 1'b0;
      end
      imu_ups_pkg::S_DOT: begin
        // products land in the cycle after their operands
        if ((cnt != 6'd0) && (cnt <= 6'd4)) dot <= dot + 36'(mprod >>> 30);
        if (cnt == 6'd5) lin <= lin_d;
      end
      imu_ups_pkg::S_SQ: begin
        if (cnt == 6'd1) begin
          sq_n   <= (64'd1 << 60) - mprod[63:0];
          sq_res <= 64'd0;
          sq_bit <= 64'd1 << 62;
        end
      end
      imu_ups_pkg::S_SQRT: begin
        if (sq_bit != 64'd0) begin
          if (sq_ge) begin
            sq_n   <= sq_n - sq_t;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end else begin
          sinth <= sq_res[30:0];
          if (sq_res == 64'd0) lin <= 1'b1;
          cx <= dot_abs;
          cy <= $signed({5'd0, sq_res[30:0]});
          cz <= 36'sd0;
        end
      end
      imu_ups_pkg::S_ANG: begin
        cx <= cx_n;
        cy <= cy_n;
        cz <= cz_n;
        if (cnt[4:0] == imu_ups_pkg::CORDIC_LAST) theta <= cz_n;
      end
      imu_ups_pkg::S_KSTART: begin
        arem  <= {27'd0, kp};
        alpha <= '0;
      end
      imu_ups_pkg::S_ALPHA: begin
        arem  <= a_ge ? ar2 - {1'b0, gap} : ar2;
        alpha <= {alpha[AB-2:0], a_ge};
      end
      imu_ups_pkg::S_SCALE: begin
        if (lin) begin
          s0 <= 32'(imu_ups_pkg::Q30_ONE) - $signed({2'b00, t30});
          s1 <= negd ? -$signed({2'b00, t30}) : $signed({2'b00, t30});
        end
      end
      imu_ups_pkg::S_A1: begin
        if (cnt == 6'd1) begin
          a1 <= 36'(mprod >>> 30);
          cx <= imu_ups_pkg::GAIN_INV;
          cy <= 36'sd0;
          cz <= theta - 36'(mprod >>> 30);
        end
      end
      imu_ups_pkg::S_SIN0, imu_ups_pkg::S_SIN1: begin
        if (cnt[4:0] == imu_ups_pkg::CORDIC_LAST) begin
          drem <= 33'(sn_c);
          dq   <= 30'd0;
          if (state == imu_ups_pkg::S_SIN0) begin
            if (sn_ge) s0 <= 32'(imu_ups_pkg::Q30_ONE);
            cx <= imu_ups_pkg::GAIN_INV;
            cy <= 36'sd0;
            cz <= a1;
          end else if (sn_ge) begin
            s1 <= negd ? -32'(imu_ups_pkg::Q30_ONE) : 32'(imu_ups_pkg::Q30_ONE);
          end
        end else begin
          cx <= cx_n;
          cy <= cy_n;
          cz <= cz_n;
        end
      end
      imu_ups_pkg::S_DIV0, imu_ups_pkg::S_DIV1: begin
        drem <= d_ge ? dr2 - {2'b00, sinth} : dr2;
        dq   <= dq_n;
        if (cnt == 6'd29) begin
          if (state == imu_ups_pkg::S_DIV0) s0 <= $signed({2'b00, dq_n});
          else s1 <= negd ? -$signed({2'b00, dq_n}) : $signed({2'b00, dq_n});
        end
      end
      imu_ups_pkg::S_QMUL: begin
        if (cnt != 6'd0) begin
          if (cnt[0]) acc <= 66'(mprod);
          else res_q[qi] <= qsat;
        end
      end
      imu_ups_pkg::S_LMUL: begin
        if (cnt != 6'd0) begin
          res_l[lc] <= cdiff[32] ? lp_a[lc] - 32'(lstep) : lp_a[lc] + 32'(lstep);
        end
      end
      imu_ups_pkg::S_EMIT: begin
        if (out_free && next_ok) begin
          kidx <= kidx + 6'd1;
          kp   <= kp + {7'd0, period};
        end
      end
      imu_ups_pkg::S_RAW: begin
        if (out_free) begin
          for (int i = 0; i < 4; i++) prev_q[i] <= cur_q[i];
          for (int i = 0; i < 3; i++) begin
            prev_g[i] <= cur_g[i];
            prev_a[i] <= cur_a[i];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == imu_ups_pkg::S_EMIT) begin
        out_timestamp_ns <= prev_time + {26'd0, kp};
        out_quat_w  <= res_q[0];
        out_quat_x  <= res_q[1];
        out_quat_y  <= res_q[2];
        out_quat_z  <= res_q[3];
        out_gyro_x  <= res_l[0];
        out_gyro_y  <= res_l[1];
        out_gyro_z  <= res_l[2];
        out_accel_x <= res_l[3];
        out_accel_y <= res_l[4];
        out_accel_z <= res_l[5];
        last_of_run <= 1'b0;
      end else begin
        out_timestamp_ns <= cur_time;
        out_quat_w  <= cur_q[0];
        out_quat_x  <= cur_q[1];
        out_quat_y  <= cur_q[2];
        out_quat_z  <= cur_q[3];
        out_gyro_x  <= cur_g[0];
        out_gyro_y  <= cur_g[1];
        out_gyro_z  <= cur_g[2];
        out_accel_x <= cur_a[0];
        out_accel_y <= cur_a[1];
        out_accel_z <= cur_a[2];
        last_of_run <= 1'b1;
      end
    end
  end

  // checks
  a_fill_count: assert property (@(posedge clk) disable iff (rst)
    state == imu_ups_pkg::S_EMIT |-> (kidx != 6'd0) && (kidx <= 6'(MAX_FILL)))
    else $error("fill index out of range");

  a_scale_range: assert property (@(posedge clk) disable iff (rst)
    state == imu_ups_pkg::S_QMUL |-> (s0 >= 32'sd0) && (s0 <= 32'(imu_ups_pkg::Q30_ONE)))
    else $error("slerp scale out of range");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> state == imu_ups_pkg::S_GAP)
    else $error("accepted sample did not start work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> !out_load)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

/* test/imu_sample_upsampler_slerp_top_tb.sv */
// imu_sample_upsampler_slerp_top_tb: self-checking bench for the imu upsampler,
// with a bit-exact interpolation predictor held in a small scoreboard class
// depends on imu_ups_pkg and imu_sample_upsampler_slerp_top
`timescale 1ns / 1ps

module imu_sample_upsampler_slerp_top_tb;

  localparam int FILL_CAP   = 63;
  localparam int FRAC_BITS  = 24;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint PARALLEL_EPS = 64'sd1024;
  localparam longint SIN_START = 64'sh26DD3B6A;
  localparam int IDLE_LIMIT = 20000;
  localparam longint unsigned TS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  // arctangent steps in q30 radians
  localparam longint ARCTAN[31] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001};

  typedef struct {
    logic [62:0]        ts;
    logic signed [31:0] q[4];
    logic signed [31:0] g[3];
    logic signed [31:0] a[3];
  } imu_sample_t;

  typedef struct {
    imu_sample_t s;
    logic        last;
  } imu_result_t;

  class upsample_scoreboard;
    imu_result_t pending_q[$];
    logic [29:0] period;
    bit          have_prev;
    imu_sample_t prev;
    int          errors;

    function new();
      period = imu_ups_pkg::PERIOD_RESET;
      have_prev = 0;
      errors = 0;
      prev.ts = '0;
      foreach (prev.q[i]) prev.q[i] = '0;
      foreach (prev.g[i]) begin
        prev.g[i] = '0;
        prev.a[i] = '0;
      end
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // cordic vectoring: angle of (x, y)
    function longint vec_angle(longint x, longint y);
      longint z, nx, ny;
      z = 0;
      for (int i = 0; i < 31; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z += ARCTAN[i];
        end else begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z -= ARCTAN[i];
        end
        x = nx;
        y = ny;
      end
      return z;
    endfunction

    // cordic rotation: sine of z
    function longint rot_sine(longint z);
      longint x, y, nx, ny;
      x = SIN_START;
      y = 0;
      for (int i = 0; i < 31; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z -= ARCTAN[i];
        end else begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z += ARCTAN[i];
        end
        x = nx;
        y = ny;
      end
      return y;
    endfunction

    function logic signed [31:0] blend_linear(longint a, longint b, longint unsigned alpha);
      longint diff;
      longint unsigned mag, d;
      diff = b - a;
      mag = (diff < 0) ? longint'(-diff) : diff;
      d = (mag * alpha + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return (diff < 0) ? 32'(a - longint'(d)) : 32'(a + longint'(d));
    endfunction

    function longint clip_unit(longint v);
      if (v < 0) return 0;
      return (v > ONE_Q30) ? ONE_Q30 : v;
    endfunction

    // expected fills and raw sample for one accepted request
    function void note_request(imu_sample_t s);
      longint unsigned gap, cnt, num, alpha, t30;
      longint dot, absd, theta, sinth, s0, s1, a0, a1, sn0, sn1, v;
      bit lin, negd;
      imu_result_t r;
      if (have_prev && s.ts > prev.ts && period != 0) begin
        gap = 64'(s.ts) - 64'(prev.ts);
        cnt = gap / period;
        cnt = (cnt >= 2) ? cnt - 1 : 0;
        if (cnt > FILL_CAP) cnt = FILL_CAP;
        dot = 0;
        for (int i = 0; i < 4; i++)
          dot += (longint'(prev.q[i]) * longint'(s.q[i])) >>> 30;
        negd = dot < 0;
        absd = negd ? -dot : dot;
        lin = absd >= ONE_Q30 - PARALLEL_EPS;
        theta = 0;
        sinth = 0;
        if (!lin) begin
          sinth = int_sqrt(64'(ONE_Q30 * ONE_Q30 - absd * absd));
          if (sinth == 0) lin = 1;
          else theta = vec_angle(absd, sinth);
        end
        for (longint unsigned k = 1; k <= cnt; k++) begin
          num = k * period;
          alpha = 0;
          for (int b = 0; b < FRAC_BITS; b++) begin
            num <<= 1;
            alpha <<= 1;
            if (num >= gap) begin
              num -= gap;
              alpha |= 1;
            end
          end
          t30 = alpha << (30 - FRAC_BITS);
          if (lin) begin
            s0 = ONE_Q30 - longint'(t30);
            s1 = longint'(t30);
          end else begin
            a1 = longint'((t30 * 64'(theta)) >> 30);
            a0 = theta - a1;
            sn0 = rot_sine(a0);
            sn1 = rot_sine(a1);
            if (sn0 < 0) sn0 = 0;
            if (sn1 < 0) sn1 = 0;
            s0 = longint'((64'(sn0) << 30) / 64'(sinth));
            s1 = longint'((64'(sn1) << 30) / 64'(sinth));
          end
          s0 = clip_unit(s0);
          s1 = clip_unit(s1);
          if (negd) s1 = -s1;
          r.s.ts = 63'(64'(prev.ts) + k * period);
          for (int i = 0; i < 4; i++) begin
            v = (s0 * longint'(prev.q[i]) + s1 * longint'(s.q[i]) + (ONE_Q30 >>> 1)) >>> 30;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            r.s.q[i] = 32'(v);
          end
          for (int i = 0; i < 3; i++) begin
            r.s.g[i] = blend_linear(prev.g[i], s.g[i], alpha);
            r.s.a[i] = blend_linear(prev.a[i], s.a[i], alpha);
          end
          r.last = 0;
          pending_q.push_back(r);
        end
      end
      r.s = s;
      r.last = 1;
      pending_q.push_back(r);
      have_prev = 1;
      prev = s;
    endfunction

    function void check_result(imu_result_t got);
      imu_result_t want;
      bit bad;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result ts=%0d last=%0b", got.s.ts, got.last);
        return;
      end
      want = pending_q.pop_front();
      bad = (got.s.ts !== want.s.ts) || (got.last !== want.last);
      for (int i = 0; i < 4; i++) bad |= got.s.q[i] !== want.s.q[i];
      for (int i = 0; i < 3; i++) bad |= (got.s.g[i] !== want.s.g[i]) ||
                                        (got.s.a[i] !== want.s.a[i]);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch exp ts=%0d q=%h %h %h %h g=%h %h %h a=%h %h %h last=%0b",
                   want.s.ts, want.s.q[0], want.s.q[1], want.s.q[2], want.s.q[3],
                   want.s.g[0], want.s.g[1], want.s.g[2],
                   want.s.a[0], want.s.a[1], want.s.a[2], want.last);
          $display("         got ts=%0d q=%h %h %h %h g=%h %h %h a=%h %h %h last=%0b",
                   got.s.ts, got.s.q[0], got.s.q[1], got.s.q[2], got.s.q[3],
                   got.s.g[0], got.s.g[1], got.s.g[2],
                   got.s.a[0], got.s.a[1], got.s.a[2], got.last);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire [31:0] prdata;
  wire pready;
  logic sample_valid = 0;
  wire sample_stall;
  logic [62:0] timestamp_ns = '0;
  logic signed [31:0] quat_w = 0, quat_x = 0, quat_y = 0, quat_z = 0;
  logic signed [31:0] gyro_x = 0, gyro_y = 0, gyro_z = 0;
  logic signed [31:0] accel_x = 0, accel_y = 0, accel_z = 0;
  wire result_valid;
  logic result_stall = 0;
  wire [62:0] out_timestamp_ns;
  wire signed [31:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  wire signed [31:0] out_gyro_x, out_gyro_y, out_gyro_z;
  wire signed [31:0] out_accel_x, out_accel_y, out_accel_z;
  wire last_of_run;

  imu_sample_upsampler_slerp_top u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .timestamp_ns(timestamp_ns),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .result_valid(result_valid), .result_stall(result_stall),
    .out_timestamp_ns(out_timestamp_ns),
    .out_quat_w(out_quat_w), .out_quat_x(out_quat_x), .out_quat_y(out_quat_y),
    .out_quat_z(out_quat_z),
    .out_gyro_x(out_gyro_x), .out_gyro_y(out_gyro_y), .out_gyro_z(out_gyro_z),
    .out_accel_x(out_accel_x), .out_accel_y(out_accel_y), .out_accel_z(out_accel_z),
    .last_of_run(last_of_run)
  );

  upsample_scoreboard sb = new();
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_tick = 0;
  longint unsigned cur_ts = 0;
  imu_sample_t last_sent;

  // clock
  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // result stall pattern: none, light, heavy, periodic
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    case (stall_tick[8:7])
      2'd0: result_stall <= 0;
      2'd1: result_stall <= ($urandom_range(0, 3) == 0);
      2'd2: result_stall <= ($urandom_range(0, 3) != 0);
      default: result_stall <= (stall_tick[2:0] < 3'd5);
    endcase
  end

  // monitor both channels and run the watchdog
  always @(posedge clk) begin
    imu_sample_t s;
    imu_result_t r;
    if (!rst) begin
      if (sample_valid && !sample_stall) begin
        s.ts = timestamp_ns;
        s.q = '{quat_w, quat_x, quat_y, quat_z};
        s.g = '{gyro_x, gyro_y, gyro_z};
        s.a = '{accel_x, accel_y, accel_z};
        sb.note_request(s);
      end
      if (result_valid && !result_stall) begin
        r.s.ts = out_timestamp_ns;
        r.s.q = '{out_quat_w, out_quat_x, out_quat_y, out_quat_z};
        r.s.g = '{out_gyro_x, out_gyro_y, out_gyro_z};
        r.s.a = '{out_accel_x, out_accel_y, out_accel_z};
        r.last = last_of_run;
        sb.check_result(r);
      end
      if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
        idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
        $display("imu_sample_upsampler_slerp_top_tb: errors");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // one request; valid stays up only inside a burst
  task automatic send(imu_sample_t s, bit more);
    sample_valid <= 1;
    timestamp_ns <= s.ts;
    {quat_w, quat_x, quat_y, quat_z} <= {s.q[0], s.q[1], s.q[2], s.q[3]};
    {gyro_x, gyro_y, gyro_z} <= {s.g[0], s.g[1], s.g[2]};
    {accel_x, accel_y, accel_z} <= {s.a[0], s.a[1], s.a[2]};
    do @(posedge clk); while (sample_stall);
    last_sent = s;
    if (more && burst_left > 0) begin
      burst_left--;
    end else begin
      sample_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 8);
    end
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_period(logic [29:0] p);
    drain();
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= 3'(imu_ups_pkg::REG_PERIOD * 4);
    pwdata <= 32'(p);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.period = p;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'(int'($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  // quaternion kinds: 0 unit, 1 near previous, 2 opposite previous, 3 raw bits, 4 nearby
  function automatic void make_quat(int kind, ref imu_sample_t s);
    real c[4];
    real nrm;
    case (kind)
      1: foreach (s.q[i]) s.q[i] = last_sent.q[i] + int'($urandom_range(0, 128)) - 64;
      2: foreach (s.q[i]) s.q[i] = -last_sent.q[i] + int'($urandom_range(0, 128)) - 64;
      3: foreach (s.q[i]) s.q[i] = $urandom;
      4: foreach (s.q[i])
        s.q[i] = last_sent.q[i] + int'($urandom_range(0, 32'h80000)) - 32'h40000;
      default: begin
        nrm = 0;
        foreach (c[i]) begin
          c[i] = (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0;
          nrm += c[i] * c[i];
        end
        nrm = $sqrt(nrm);
        if (nrm < 0.001) begin
          c = '{1.0, 0.0, 0.0, 0.0};
          nrm = 1.0;
        end
        foreach (s.q[i]) s.q[i] = $rtoi(c[i] / nrm * 1073741823.0);
      end
    endcase
  endfunction

  function automatic imu_sample_t make_sample(longint unsigned ts, int qkind);
    imu_sample_t s;
    s.ts = ts[62:0];
    make_quat(qkind, s);
    foreach (s.g[i]) begin
      s.g[i] = rand_word();
      s.a[i] = rand_word();
    end
    return s;
  endfunction

  // random gap: mostly a few periods, sometimes short, repeated, backward, very long or random
  function automatic longint unsigned next_ts(longint unsigned p);
    longint unsigned span;
    span = (p == 0) ? 64'd5000000 : p;
    case ($urandom_range(0, 19))
      0: return cur_ts;
      1: return (cur_ts - $urandom_range(1, 100000)) & TS_MAX;
      2: return (cur_ts + span * $urandom_range(64, 70) + $urandom_range(0, 999)) & TS_MAX;
      3: return (cur_ts + $urandom_range(0, 32'(2 * span - 1))) & TS_MAX;
      4: return {$urandom, $urandom} & TS_MAX;
      default:
        return (cur_ts + span * $urandom_range(2, 10) + ($urandom % span)) & TS_MAX;
    endcase
  endfunction

  task automatic random_phase(int n);
    imu_sample_t s;
    int qk;
    for (int i = 0; i < n; i++) begin
      cur_ts = next_ts(sb.period);
      case ($urandom_range(0, 9))
        0, 1, 2: qk = 0;
        3, 4: qk = 1;
        5: qk = 2;
        6: qk = 3;
        default: qk = 4;
      endcase
      s = make_sample(cur_ts, qk);
      send(s, i != n - 1);
    end
  endtask

  initial begin
    imu_sample_t s;
    longint unsigned p;
    p = imu_ups_pkg::PERIOD_RESET;
    last_sent = sb.prev;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // first sample after reset: raw only
    s = make_sample(0, 0);
    s.q = '{32'sd1073741824, 0, 0, 0};
    send(s, 1);
    // three periods: two fills, extremes on gyro and accel
    cur_ts = 3 * p;
    s = make_sample(cur_ts, 4);
    s.g = '{32'sh7FFFFFFF, 32'sh80000000, 0};
    s.a = '{32'sh80000000, 32'sh7FFFFFFF, -1};
    send(s, 1);
    // exactly two periods, then just short of two periods
    cur_ts += 2 * p;
    send(make_sample(cur_ts, 0), 1);
    cur_ts += 2 * p - 1;
    send(make_sample(cur_ts, 0), 1);
    // repeated timestamp and a step backward
    send(make_sample(cur_ts, 0), 1);
    cur_ts -= 7;
    send(make_sample(cur_ts, 1), 1);
    // far too many fills, capped
    cur_ts += 100 * p;
    send(make_sample(cur_ts, 2), 1);
    // near-parallel and opposite quaternions
    cur_ts += 5 * p;
    send(make_sample(cur_ts, 1), 1);
    cur_ts += 5 * p + 3;
    send(make_sample(cur_ts, 2), 1);
    // saturating quaternions, all fields at extremes
    cur_ts += 4 * p;
    s = make_sample(cur_ts, 0);
    s.q = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
    s.g = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
    s.a = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
    send(s, 1);
    cur_ts += 6 * p;
    s = make_sample(cur_ts, 0);
    s.q = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000};
    s.g = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
    s.a = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
    send(s, 1);
    cur_ts += 3 * p;
    send(make_sample(cur_ts, 3), 1);
    // top of the timestamp range
    cur_ts = TS_MAX - 8 * p;
    send(make_sample(cur_ts, 0), 1);
    cur_ts = TS_MAX;
    send(make_sample(cur_ts, 4), 0);

    // hold off until every result is back
    while (sb.pending_q.size() != 0) @(posedge clk);
    cur_ts = 64'd1000000;
    random_phase(10);

    write_period(30'd1000);
    random_phase(30);
    write_period(30'd1000000000);
    random_phase(15);
    write_period(30'd0);
    random_phase(6);
    write_period(30'($urandom_range(1000, 5000000)));
    random_phase(25);
    write_period(imu_ups_pkg::PERIOD_RESET);
    random_phase(15);

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("imu_sample_upsampler_slerp_top_tb: clean");
    end else begin
      $display("imu_sample_upsampler_slerp_top_tb: errors");
    end
    $finish;
  end

endmodule
